FILE: hw/rtl/pgpc_pkg.sv
// Shared constants, register map and gear coding for the gear position classifier.
`default_nettype none

package pgpc_pkg;

	// Default build values for the top-level parameters
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int DECIMATION_DEF  = 8;

	// Configuration port
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_ENABLE  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_PARK    = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_NEUTRAL = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_DRIVE   = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_REVERSE = REG_IDX_W'(4);

	// Reset values of the configured positions (ADC counts)
	localparam int PARK_RST    = 1830;
	localparam int NEUTRAL_RST = 1400;
	localparam int DRIVE_RST   = 1200;
	localparam int REVERSE_RST = 1630;

	// Plausibility window on the filtered position
	localparam int                LIMIT_W    = 16;
	localparam logic [LIMIT_W-1:0] LOW_LIMIT  = LIMIT_W'(100);
	localparam logic [LIMIT_W-1:0] HIGH_LIMIT = LIMIT_W'(4000);

	// Position slots, in tie-break order
	localparam int NUM_POS = 4;
	localparam logic [1:0] POS_PARK    = 2'd0;
	localparam logic [1:0] POS_NEUTRAL = 2'd1;
	localparam logic [1:0] POS_DRIVE   = 2'd2;
	localparam logic [1:0] POS_REVERSE = 2'd3;

	typedef enum logic [1:0] {
		GEAR_NEUTRAL = 2'd0,
		GEAR_DRIVE   = 2'd1,
		GEAR_REVERSE = 2'd2
	} gear_t;

	function automatic gear_t gear_of(input logic [1:0] pos);
		gear_t g;
		unique case (pos)
			POS_DRIVE:   g = GEAR_DRIVE;
			POS_REVERSE: g = GEAR_REVERSE;
			default:     g = GEAR_NEUTRAL;
		endcase
		return g;
	endfunction

	function automatic logic enable_of(input logic [1:0] pos);
		return (pos == POS_DRIVE) || (pos == POS_REVERSE);
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pot_gear_position_classifier.sv
// Top level of the potentiometer gear position classifier.
`default_nettype none

// Takes one raw potentiometer ADC sample per transaction and smooths it as
// acc = (4*acc + sample)/5 (truncating; the /5 is a constant reciprocal
// multiply). Every DECIMATION-th sample taken while enabled yields one result
// transaction: the configured position (park, neutral, drive, reverse, ties
// going to the earlier one) nearest the smoothed value picks gear and
// drive_enable; park and neutral give neutral/disabled. A smoothed value below
// 100 or above 4000 forces neutral/disabled and sets out_of_range;
// filtered_position always carries the smoothed value. With enable cleared,
// samples are still taken but ignored. Throughput is one sample per clock
// while sample_stall is low; the pipeline is input register, filter
// accumulator and result register. A result held under result_stall does
// not stop the filter by itself: sample_stall rises only while the next
// result is ready behind it and cannot move into the result register.
// Write configuration only when the block is idle.
// No clearing pass after reset: the block takes samples at once.

module pot_gear_position_classifier import pgpc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int DECIMATION  = DECIMATION_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// sample channel
	input  wire logic                   sample_valid,
	output      logic                   sample_stall,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	// result channel
	output      logic                   result_valid,
	input  wire logic                   result_stall,
	output      logic [1:0]             gear,
	output      logic                   drive_enable,
	output      logic                   out_of_range,
	output      logic [SAMPLE_BITS-1:0] filtered_position,
	// configuration
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [ADDR_W-1:0]      paddr,
	input  wire logic [DATA_W-1:0]      pwdata,
	output      logic [DATA_W-1:0]      prdata,
	output      logic                   pready
);

	logic                   enable;
	logic [SAMPLE_BITS-1:0] pos [NUM_POS];
	logic                   out_free;
	logic                   advance;
	logic                   res_s2;
	logic [SAMPLE_BITS-1:0] acc;

	// result register can load unless its transaction is held back
	assign out_free     = !(result_valid && result_stall);
	// filter only waits when a finished result has nowhere to go
	assign advance      = out_free || !res_s2;
	assign sample_stall = !advance;
	assign pready       = 1'b1;

	pgpc_regs #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.enable  (enable),
		.pos     (pos)
	);

	pgpc_filter #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.DECIMATION (DECIMATION)
	) u_filter (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.enable       (enable),
		.sample_valid (sample_valid),
		.sample       (sample),
		.res_s2       (res_s2),
		.acc          (acc)
	);

	pgpc_classify #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_classify (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (out_free),
		.res_s2            (res_s2),
		.acc               (acc),
		.pos               (pos),
		.result_valid      (result_valid),
		.gear              (gear),
		.drive_enable      (drive_enable),
		.out_of_range      (out_of_range),
		.filtered_position (filtered_position)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/pgpc_regs.sv
// APB register bank: enable bit and the four configured gear positions.
`default_nettype none

module pgpc_regs import pgpc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [ADDR_W-1:0]      paddr,
	input  wire logic [DATA_W-1:0]      pwdata,
	output      logic [DATA_W-1:0]      prdata,
	output      logic                   enable,
	output      logic [SAMPLE_BITS-1:0] pos [NUM_POS]
);

	logic                   enable_q;
	logic [SAMPLE_BITS-1:0] pos_q [NUM_POS];
	logic [REG_IDX_W-1:0]   idx;
	logic                   wr;

	assign idx = paddr[ADDR_W-1:2];
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q           <= 1'b1;
			pos_q[POS_PARK]    <= SAMPLE_BITS'(PARK_RST);
			pos_q[POS_NEUTRAL] <= SAMPLE_BITS'(NEUTRAL_RST);
			pos_q[POS_DRIVE]   <= SAMPLE_BITS'(DRIVE_RST);
			pos_q[POS_REVERSE] <= SAMPLE_BITS'(REVERSE_RST);
		end else if (wr) begin
			unique case (idx)
				REG_ENABLE:  enable_q           <= pwdata[0];
				REG_PARK:    pos_q[POS_PARK]    <= pwdata[SAMPLE_BITS-1:0];
				REG_NEUTRAL: pos_q[POS_NEUTRAL] <= pwdata[SAMPLE_BITS-1:0];
				REG_DRIVE:   pos_q[POS_DRIVE]   <= pwdata[SAMPLE_BITS-1:0];
				REG_REVERSE: pos_q[POS_REVERSE] <= pwdata[SAMPLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ENABLE:  prdata = DATA_W'(enable_q);
			REG_PARK:    prdata = DATA_W'(pos_q[POS_PARK]);
			REG_NEUTRAL: prdata = DATA_W'(pos_q[POS_NEUTRAL]);
			REG_DRIVE:   prdata = DATA_W'(pos_q[POS_DRIVE]);
			REG_REVERSE: prdata = DATA_W'(pos_q[POS_REVERSE]);
			default:     prdata = '0;
		endcase
	end

	assign enable = enable_q;
	assign pos    = pos_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pgpc_filter.sv
// Input register, 4/5 smoothing filter and decimation counter.
`default_nettype none

module pgpc_filter import pgpc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int DECIMATION  = DECIMATION_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire logic                   enable,
	input  wire logic                   sample_valid,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	output      logic                   res_s2,
	output      logic [SAMPLE_BITS-1:0] acc
);

	// acc*4 + sample fits in SAMPLE_BITS+3 bits
	localparam int XW    = SAMPLE_BITS + 3;
	// Rounded-up reciprocal of 5 with 3 guard bits: exact for every x < 2**XW
	localparam int KSH   = XW + 3;
	localparam int MW    = KSH - 1;
	localparam int PW    = XW + MW;
	localparam logic [MW-1:0] RECIP5 = MW'(((64'd1 << KSH) + 64'd4) / 64'd5);
	localparam int CNT_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DECIMATION - 1);

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [SAMPLE_BITS-1:0] acc_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   res_s2_q;
	logic [XW-1:0]          sum;
	logic [PW-1:0]          prod;
	logic                   last;

	assign sum  = XW'({acc_q, 2'b00}) + XW'(sample_s1);
	assign prod = PW'(sum) * PW'(RECIP5);
	assign last = (cnt_q == CNT_LAST);

	// payload of the input register
	always_ff @(posedge clk) begin
		if (advance) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			acc_q    <= '0;
			cnt_q    <= '0;
			res_s2_q <= 1'b0;
		end else if (advance) begin
			// samples taken while disabled are dropped here
			valid_s1 <= sample_valid && enable;
			res_s2_q <= valid_s1 && last;
			if (valid_s1) begin
				acc_q <= prod[KSH +: SAMPLE_BITS];
				cnt_q <= last ? '0 : cnt_q + CNT_W'(1);
			end
		end
	end

	assign res_s2 = res_s2_q;
	assign acc    = acc_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pgpc_classify.sv
// Nearest-position search, range check and result register.
`default_nettype none

module pgpc_classify import pgpc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire logic                   res_s2,
	input  wire logic [SAMPLE_BITS-1:0] acc,
	input  wire logic [SAMPLE_BITS-1:0] pos [NUM_POS],
	output      logic                   result_valid,
	output      logic [1:0]             gear,
	output      logic                   drive_enable,
	output      logic                   out_of_range,
	output      logic [SAMPLE_BITS-1:0] filtered_position
);

	logic [SAMPLE_BITS-1:0] pos_gap [NUM_POS];
	logic [SAMPLE_BITS-1:0] lowest;
	logic [1:0]             best;
	logic                   oor;
	logic                   valid_q;
	gear_t                  gear_q;
	logic                   en_q;
	logic                   oor_q;
	logic [SAMPLE_BITS-1:0] filt_q;

	always_comb begin
		for (int i = 0; i < NUM_POS; i++) begin
			pos_gap[i] = (acc >= pos[i]) ? acc - pos[i] : pos[i] - acc;
		end
	end

	// strict less-than: the earlier slot keeps a tie
	always_comb begin
		lowest = pos_gap[0];
		best   = POS_PARK;
		for (int i = 1; i < NUM_POS; i++) begin
			if (pos_gap[i] < lowest) begin
				lowest = pos_gap[i];
				best   = 2'(i);
			end
		end
	end

	assign oor = (LIMIT_W'(acc) < LOW_LIMIT) || (LIMIT_W'(acc) > HIGH_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_s2) begin
			gear_q <= oor ? GEAR_NEUTRAL : gear_of(best);
			en_q   <= !oor && enable_of(best);
			oor_q  <= oor;
			filt_q <= acc;
		end
	end

	assign result_valid      = valid_q;
	assign gear              = gear_q;
	assign drive_enable      = en_q;
	assign out_of_range      = oor_q;
	assign filtered_position = filt_q;

endmodule

`default_nettype wire
